// ===== hdl/lpl_pkg.sv =====
`timescale 1ns / 1ps

package lpl_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int Q15_W         = 15;
	localparam int LEN_CFG_W     = 8;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 15;
	localparam int SERIAL_STEPS  = 15;
	localparam int STEP_W        = 4;
	localparam int MAX_DELAY_DEF = 128;

	localparam logic [Q15_W-1:0] Q15_ONE = 15'h7fff;

	localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd4;

	localparam logic [Q15_W-1:0]     ATTACK_RST    = 15'd6553;
	localparam logic [Q15_W-1:0]     RELEASE_RST   = 15'd16383;
	localparam logic [Q15_W-1:0]     THRESHOLD_RST = 15'd29490;
	localparam logic [LEN_CFG_W-1:0] DELAY_RST     = 8'd100;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_DIV,
		ST_MUL2,
		ST_MUL3,
		ST_DONE
	} lpl_state_t;

	typedef struct packed {
		logic push;
		logic clear;
	} dl_ctl_t;

endpackage

// ===== hdl/lookahead_peak_limiter_q15_unit.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// in      | into      | in_valid / in_stall   | sample_in, block_end_in
// out     | out of    | out_valid / out_stall | sample_out, block_end_out
// cfg     | into      | cfg_valid / cfg_ready | cfg_index, cfg_data
// enabled: bit-serial multiplies, plus a bit-serial divide when the envelope is above threshold; disabled: bypass
// a new sample is taken in only once the previous one has reached the output register
// reset and coefficient writes need no clearing pass: a fill flag zeroes unwritten taps
// a result waits in the output register while the next sample is taken in

module lookahead_peak_limiter_q15_unit import lpl_pkg::*; #(
	parameter int MAX_DELAY = MAX_DELAY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [SAMPLE_W-1:0]  sample_in,
	input  logic                        block_end_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [SAMPLE_W-1:0]  sample_out,
	output logic                        block_end_out,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	lpl_state_t state_q, state_d;

	logic [Q15_W-1:0]     attack_q;
	logic [Q15_W-1:0]     release_q;
	logic [Q15_W-1:0]     thresh_q;
	logic [LEN_CFG_W-1:0] delay_q;
	logic                 enable_q;
	logic [Q15_W-1:0]     env_q;
	logic [Q15_W-1:0]     gain_q;

	logic [Q15_W-1:0]           mag_q;
	logic                       bend_q;
	logic [Q15_W-1:0]           ga_q;
	logic signed [SAMPLE_W-1:0] res_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_bend_q;

	logic in_xfer, out_xfer, cfg_wr, cfg_clr;
	logic env_ld, gain_ld, ga_ld, res_ld, out_ld;

	logic [SAMPLE_W-1:0] sample_neg;
	logic [Q15_W-1:0]    mag_in;
	logic [Q15_W-1:0]    decayed;
	logic [Q15_W-1:0]    new_env;
	logic [Q15_W-1:0]    keep;
	logic [Q15_W:0]      gain_sum;
	logic [Q15_W-1:0]    gain_new;

	logic                       mul_e_start, mul_e_done;
	logic [Q15_W-1:0]           mul_e_a;
	logic signed [SAMPLE_W-1:0] mul_e_b, mul_e_prod;
	logic                       mul_g_done;
	logic signed [SAMPLE_W-1:0] mul_g_prod;
	logic                       div_start, div_done;
	logic [Q15_W-1:0]           div_quot;
	dl_ctl_t                    dl_ctl;
	logic signed [SAMPLE_W-1:0] dl_rd;

	assign in_stall  = state_q != ST_IDLE;
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		cfg_clr    = cfg_wr && (cfg_index inside {REG_ATTACK, REG_RELEASE,
			REG_THRESHOLD, REG_DELAY});
		sample_neg = ~sample_in + 16'd1;
		if (!sample_in[SAMPLE_W-1]) begin
			mag_in = sample_in[Q15_W-1:0];
		end else if (sample_in == 16'sh8000) begin
			mag_in = Q15_ONE;
		end else begin
			mag_in = sample_neg[Q15_W-1:0];
		end
		decayed  = mul_e_prod[Q15_W-1:0];
		new_env  = (mag_q > decayed) ? mag_q : decayed;
		keep     = Q15_ONE - attack_q;
		gain_sum = {1'b0, ga_q} + {1'b0, mul_e_prod[Q15_W-1:0]};
		gain_new = (gain_sum > {1'b0, Q15_ONE}) ? Q15_ONE : gain_sum[Q15_W-1:0];
	end

	always_comb begin
		state_d     = state_q;
		mul_e_start = 1'b0;
		mul_e_a     = release_q;
		mul_e_b     = {1'b0, env_q};
		div_start   = 1'b0;
		env_ld      = 1'b0;
		gain_ld     = 1'b0;
		ga_ld       = 1'b0;
		res_ld      = 1'b0;
		out_ld      = 1'b0;
		dl_ctl      = '{push: 1'b0, clear: cfg_clr};
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (enable_q) begin
						mul_e_start = 1'b1;
						dl_ctl.push = 1'b1;
						state_d     = ST_MUL1;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MUL1: begin
				if (mul_e_done) begin
					env_ld = 1'b1;
					ga_ld  = 1'b1;
					if (new_env > thresh_q) begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end else begin
						mul_e_start = 1'b1;
						mul_e_a     = keep;
						mul_e_b     = {1'b0, Q15_ONE};
						state_d     = ST_MUL2;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					mul_e_start = 1'b1;
					mul_e_a     = keep;
					mul_e_b     = {1'b0, div_quot};
					state_d     = ST_MUL2;
				end
			end
			ST_MUL2: begin
				if (mul_e_done) begin
					gain_ld     = 1'b1;
					mul_e_start = 1'b1;
					mul_e_a     = gain_new;
					mul_e_b     = dl_rd;
					state_d     = ST_MUL3;
				end
			end
			ST_MUL3: begin
				if (mul_e_done) begin
					res_ld  = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= ATTACK_RST;
			release_q <= RELEASE_RST;
			thresh_q  <= THRESHOLD_RST;
			delay_q   <= DELAY_RST;
			enable_q  <= 1'b1;
			env_q     <= '0;
			gain_q    <= Q15_ONE;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					REG_ATTACK:    attack_q  <= cfg_data[Q15_W-1:0];
					REG_RELEASE:   release_q <= cfg_data[Q15_W-1:0];
					REG_THRESHOLD: thresh_q  <= cfg_data[Q15_W-1:0];
					REG_DELAY:     delay_q   <= cfg_data[LEN_CFG_W-1:0];
					REG_ENABLE:    enable_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cfg_clr) begin
				env_q  <= '0;
				gain_q <= Q15_ONE;
			end else begin
				if (env_ld) begin
					env_q <= new_env;
				end
				if (gain_ld) begin
					gain_q <= gain_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mag_q  <= mag_in;
			bend_q <= block_end_in;
			res_q  <= sample_in;
		end
		if (ga_ld) begin
			ga_q <= mul_g_prod[Q15_W-1:0];
		end
		if (res_ld) begin
			res_q <= mul_e_prod;
		end
		if (out_ld) begin
			out_sample_q <= res_q;
			out_bend_q   <= bend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign sample_out    = out_sample_q;
	assign block_end_out = out_bend_q;

	// envelope decay, then gain terms and the output scaling
	lpl_mul u_mul_e (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_e_start),
		.mplr   (mul_e_a),
		.mcand  (mul_e_b),
		.done   (mul_e_done),
		.prod   (mul_e_prod)
	);

	// previous gain times attack, alongside the decay
	lpl_mul u_mul_g (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_e_start && (state_q == ST_IDLE)),
		.mplr   (attack_q),
		.mcand  ({1'b0, gain_q}),
		.done   (mul_g_done),
		.prod   (mul_g_prod)
	);

	lpl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (thresh_q),
		.den    (new_env),
		.done   (div_done),
		.quot   (div_quot)
	);

	lpl_dline #(
		.MAX_DELAY (MAX_DELAY)
	) u_dline (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (dl_ctl),
		.delay_length (delay_q),
		.wr_data      (sample_in),
		.rd_data      (dl_rd)
	);

	a_mul_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL1) |-> (mul_e_done == mul_g_done))
		else $error("gain and decay multiplies out of step");

	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !enable_q) |=> (state_q == ST_DONE))
		else $error("disabled sample did not go straight to output");

	a_div_above: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_done) |-> (env_q > thresh_q))
		else $error("divide finished with envelope at or below threshold");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && out_stall) |=> (state_q == ST_DONE))
		else $error("result left pending stage while output register full");

endmodule

// ===== hdl/lpl_mul.sv =====
`timescale 1ns / 1ps

module lpl_mul import lpl_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [Q15_W-1:0]           mplr,
	input  logic signed [SAMPLE_W-1:0] mcand,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] prod
);

	logic [Q15_W-1:0]           mplr_q;
	logic signed [SAMPLE_W-1:0] mcand_q;
	logic signed [SAMPLE_W-1:0] acc_q;
	logic [STEP_W-1:0]          cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [SAMPLE_W:0]          sum;

	// one multiplier bit per cycle, product shifted right as it grows
	always_comb begin
		sum = {acc_q[SAMPLE_W-1], acc_q}
			+ (mplr_q[0] ? {mcand_q[SAMPLE_W-1], mcand_q} : {(SAMPLE_W+1){1'b0}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == STEP_W'(1));
			if (start) begin
				cnt_q  <= STEP_W'(SERIAL_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mplr_q  <= mplr;
			mcand_q <= mcand;
			acc_q   <= '0;
		end else if (busy_q) begin
			mplr_q <= mplr_q >> 1;
			acc_q  <= sum[SAMPLE_W:1];
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== hdl/lpl_div.sv =====
`timescale 1ns / 1ps

module lpl_div import lpl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [Q15_W-1:0] num,
	input  logic [Q15_W-1:0] den,
	output logic             done,
	output logic [Q15_W-1:0] quot
);

	logic [Q15_W-1:0]  rem_q;
	logic [Q15_W-1:0]  den_q;
	logic [Q15_W-1:0]  quot_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [Q15_W:0]    rem2;
	logic [Q15_W:0]    diff;
	logic              ge;

	// restoring division of num << 15 by den, num below den
	always_comb begin
		rem2 = {rem_q, 1'b0};
		diff = rem2 - {1'b0, den_q};
		ge   = rem2 >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == STEP_W'(1));
			if (start) begin
				cnt_q  <= STEP_W'(SERIAL_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[Q15_W-1:0] : rem2[Q15_W-1:0];
			quot_q <= {quot_q[Q15_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== hdl/lpl_dline.sv =====
`timescale 1ns / 1ps

module lpl_dline import lpl_pkg::*; #(
	parameter int MAX_DELAY = MAX_DELAY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dl_ctl_t                    ctl,
	input  logic [LEN_CFG_W-1:0]       delay_length,
	input  logic signed [SAMPLE_W-1:0] wr_data,
	output logic signed [SAMPLE_W-1:0] rd_data
);

	localparam int PW    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int LEN_W = (PW + 1 > LEN_CFG_W) ? PW + 1 : LEN_CFG_W;

	logic signed [SAMPLE_W-1:0] mem [MAX_DELAY];
	logic signed [SAMPLE_W-1:0] rd_q;
	logic [PW-1:0]              wp_q;
	logic                       full_q;
	logic [PW-1:0]              wr_pos;
	logic [LEN_W-1:0]           cfg_len;
	logic [LEN_W-1:0]           len;
	logic [LEN_W-1:0]           nxt;
	logic                       wrap;

	always_comb begin
		cfg_len = LEN_W'(delay_length);
		if (cfg_len == '0) begin
			len = LEN_W'(1);
		end else if (cfg_len > LEN_W'(MAX_DELAY)) begin
			len = LEN_W'(MAX_DELAY);
		end else begin
			len = cfg_len;
		end
		wr_pos = (LEN_W'(wp_q) >= len) ? '0 : wp_q;
		nxt    = LEN_W'(wr_pos) + LEN_W'(1);
		wrap   = nxt == len;
	end

	// entries not yet written since the last clear read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			full_q <= 1'b0;
		end else if (ctl.clear) begin
			wp_q   <= '0;
			full_q <= 1'b0;
		end else if (ctl.push) begin
			wp_q <= wrap ? '0 : nxt[PW-1:0];
			if (wrap) begin
				full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_pos] <= wr_data;
		end
		rd_q <= mem[wp_q];
	end

	assign rd_data = full_q ? rd_q : '0;

endmodule

// ===== sim/tb_lookahead_peak_limiter_q15_unit.sv =====
`timescale 1ns / 1ps

module tb_lookahead_peak_limiter_q15_unit;
	import lpl_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_ENABLE + 1'b1;

	typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;
	typedef enum int {FEED_NOISE, FEED_BURSTY, FEED_QUIET} feed_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic [CFG_IDX_W-1:0]        idx;
		logic [CFG_DATA_W-1:0]       data;
		logic signed [SAMPLE_W-1:0]  smp;
		logic                        be;
		logic                        typed;
		logic signed [SAMPLE_W-1:0]  want;
	} dir_row_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smp;
		logic                       be;
	} limited_t;

	// after reset the long window still returns zeros; disabled rows pass straight through
	localparam dir_row_t DIR_ROWS [39] = '{
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd32767, 1'b1, 1'b1, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,     -16'sd32768, 1'b0, 1'b1, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd0,     1'b1, 1'b1, 16'sd0},
		'{ROW_WRITE,  REG_ENABLE,    15'd0,      16'sd0,     1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,     -16'sd32768, 1'b0, 1'b1, -16'sd32768},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd32767, 1'b1, 1'b1, 16'sd32767},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,     -16'sd1,     1'b0, 1'b1, -16'sd1},
		'{ROW_WRITE,  REG_ENABLE,    15'd1,      16'sd0,     1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd12345, 1'b0, 1'b0, 16'sd0},
		'{ROW_WRITE,  REG_DELAY,     15'd1,      16'sd0,     1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd32767, 1'b1, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,     -16'sd32768, 1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,     -16'sd1,     1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd0,     1'b1, 1'b0, 16'sd0},
		'{ROW_WRITE,  REG_DELAY,     15'd0,      16'sd0,     1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd20000, 1'b0, 1'b0, 16'sd0},
		'{ROW_WRITE,  REG_DELAY,     15'h00ff,   16'sd0,     1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,     -16'sd20000, 1'b1, 1'b0, 16'sd0},
		'{ROW_WRITE,  REG_DELAY,     15'h7f04,   16'sd0,     1'b0, 1'b0, 16'sd0},
		'{ROW_WRITE,  REG_THRESHOLD, 15'd0,      16'sd0,     1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd100,   1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,     -16'sd100,   1'b1, 1'b0, 16'sd0},
		'{ROW_WRITE,  REG_THRESHOLD, 15'h7fff,   16'sd0,     1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd32767, 1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,     -16'sd32768, 1'b1, 1'b0, 16'sd0},
		'{ROW_WRITE,  REG_ATTACK,    15'd0,      16'sd0,     1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd32767, 1'b0, 1'b0, 16'sd0},
		'{ROW_WRITE,  REG_ATTACK,    15'h7fff,   16'sd0,     1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,     -16'sd32768, 1'b0, 1'b0, 16'sd0},
		'{ROW_WRITE,  REG_RELEASE,   15'd0,      16'sd0,     1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd30000, 1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd5,     1'b1, 1'b0, 16'sd0},
		'{ROW_WRITE,  REG_RELEASE,   15'h7fff,   16'sd0,     1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd30000, 1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd5,     1'b0, 1'b0, 16'sd0},
		'{ROW_WRITE,  REG_SPARE,     15'h7fff,   16'sd0,     1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd1000,  1'b1, 1'b0, 16'sd0},
		'{ROW_WRITE,  REG_ENABLE,    15'h7ffe,   16'sd0,     1'b0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_ATTACK,    15'd0,      16'sd4242,  1'b0, 1'b1, 16'sd4242}
	};

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic                       block_end_in = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       block_end_out;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;

	lookahead_peak_limiter_q15_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_in    (sample_in),
		.block_end_in (block_end_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out),
		.block_end_out(block_end_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// limiter shadow state
	int unsigned                keep_wt;
	int unsigned                decay_wt;
	int unsigned                knee;
	int unsigned                span_cfg;
	bit                         limiting;
	logic signed [SAMPLE_W-1:0] taps [MAX_DELAY_DEF];
	int unsigned                tap_wr;
	int unsigned                env_lvl;
	int unsigned                gain_lvl;

	limited_t owed_samples [$];
	int       bad_count = 0;
	int       sent = 0;
	bit       calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic void clear_line();
		foreach (taps[i]) taps[i] = '0;
		tap_wr = 0;
		env_lvl = 0;
		gain_lvl = 32'(Q15_ONE);
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_ATTACK: begin
				keep_wt = 32'(d);
				clear_line();
			end
			REG_RELEASE: begin
				decay_wt = 32'(d);
				clear_line();
			end
			REG_THRESHOLD: begin
				knee = 32'(d);
				clear_line();
			end
			REG_DELAY: begin
				span_cfg = 32'(d[LEN_CFG_W-1:0]);
				clear_line();
			end
			REG_ENABLE: limiting = d[0];
			default: ;
		endcase
	endfunction

	function automatic int unsigned q15_mul(input int unsigned a, input int unsigned b);
		return (a * b) >> 15;
	endfunction

	function automatic limited_t limit_sample(input logic signed [SAMPLE_W-1:0] s,
			input logic be);
		int unsigned len;
		int unsigned mag;
		int unsigned decayed;
		int unsigned target;
		int unsigned g;
		int          sv;
		int          p;
		limited_t    r;
		r.smp = s;
		r.be = be;
		if (limiting) begin
			len = (span_cfg == 0) ? 1 : ((span_cfg > MAX_DELAY_DEF) ? MAX_DELAY_DEF : span_cfg);
			if (tap_wr >= len) tap_wr = 0;
			taps[tap_wr] = s;
			tap_wr = (tap_wr + 1) % len;
			sv = int'(s);
			mag = (sv < 0) ? -sv : sv;
			if (mag > Q15_ONE) mag = 32'(Q15_ONE);
			decayed = q15_mul(env_lvl, decay_wt);
			env_lvl = (mag > decayed) ? mag : decayed;
			target = 32'(Q15_ONE);
			if (env_lvl > knee) target = (knee << 15) / env_lvl;
			g = q15_mul(gain_lvl, keep_wt) + q15_mul(target, Q15_ONE - keep_wt);
			gain_lvl = (g > Q15_ONE) ? 32'(Q15_ONE) : g;
			p = int'(taps[tap_wr]) * int'(gain_lvl);
			r.smp = SAMPLE_W'(p >>> 15);
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 16);
		return $urandom_range(30, 90);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_q15(input int unsigned lo);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return Q15_ONE;
		return CFG_DATA_W'($urandom_range(lo, Q15_ONE));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_span();
		int          r;
		int unsigned len;
		r = $urandom_range(0, 19);
		if (r < 2) len = 1;
		else if (r < 4) len = MAX_DELAY_DEF;
		else if (r == 4) len = 0;
		else if (r == 5) len = $urandom_range(MAX_DELAY_DEF + 1, (1 << LEN_CFG_W) - 1);
		else len = $urandom_range(2, 16);
		return {(CFG_DATA_W - LEN_CFG_W)'($urandom), LEN_CFG_W'(len)};
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input feed_t feed);
		int v;
		case (feed)
			FEED_BURSTY: begin
				if ($urandom_range(0, 19) == 0)
					return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				if ($urandom_range(0, 9) < 3) begin
					v = $urandom_range(28000, 32767);
					if ($urandom_range(0, 1)) v = -v;
				end else begin
					v = int'($urandom_range(0, 4000)) - 2000;
				end
				return SAMPLE_W'(v);
			end
			FEED_QUIET: begin
				if ($urandom_range(0, 19) == 0) return SAMPLE_W'($urandom);
				v = int'($urandom_range(0, 1000)) - 500;
				return SAMPLE_W'(v);
			end
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (owed_samples.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic be,
			input logic typed, input logic signed [SAMPLE_W-1:0] want);
		int       gap;
		limited_t e;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		block_end_in <= be;
		do @(posedge clk); while (in_stall);
		e = limit_sample(s, be);
		if (typed) e.smp = want;
		owed_samples.push_back(e);
		sent++;
		@(negedge clk);
	endtask

	// output side backpressure
	initial begin : drain_side
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
				if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : check_out
		limited_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_samples.size() == 0) begin
				$error("sample_out transfer with no sample owed, got %0d", sample_out);
				bad_count++;
			end else begin
				e = owed_samples.pop_front();
				if (sample_out !== e.smp) begin
					$error("sample_out expected %0d got %0d", e.smp, sample_out);
					bad_count++;
				end
				if (block_end_out !== e.be) begin
					$error("block_end_out expected %0b got %0b", e.be, block_end_out);
					bad_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int    n;
		int    phase;
		feed_t feed;
		logic [CFG_DATA_W-1:0] en_word;
		keep_wt = 32'(ATTACK_RST);
		decay_wt = 32'(RELEASE_RST);
		knee = 32'(THRESHOLD_RST);
		span_cfg = 32'(DELAY_RST);
		limiting = 1'b1;
		clear_line();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
			end else begin
				push_sample(DIR_ROWS[i].smp, DIR_ROWS[i].be, DIR_ROWS[i].typed,
					DIR_ROWS[i].want);
			end
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_idle();
			if (phase == 0 || $urandom_range(0, 9) < 4) write_reg(REG_ATTACK, pick_q15(0));
			if (phase == 0 || $urandom_range(0, 9) < 4) write_reg(REG_RELEASE, pick_q15(0));
			if (phase == 0 || $urandom_range(0, 9) < 4) write_reg(REG_THRESHOLD, pick_q15(8000));
			if (phase == 0 || $urandom_range(0, 9) < 4) write_reg(REG_DELAY, pick_span());
			if (phase == 0 || $urandom_range(0, 9) < 4) begin
				en_word = CFG_DATA_W'($urandom_range(0, Q15_ONE));
				en_word[0] = ($urandom_range(0, 99) < 85);
				write_reg(REG_ENABLE, en_word);
			end
			if ($urandom_range(0, 6) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_SPARE, (1 << CFG_IDX_W) - 1)),
					CFG_DATA_W'($urandom));
			calm = ($urandom_range(0, 4) == 0);
			feed = feed_t'($urandom_range(FEED_NOISE, FEED_QUIET));
			n = $urandom_range(20, 120);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 149) == 0) wait_idle();
				push_sample(pick_sample(feed), (k == n - 1) || ($urandom_range(0, 15) == 0),
					1'b0, '0);
			end
			phase++;
		end

		calm = 1'b0;
		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (bad_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
